// ----- design/s5c_pkg.sv -----
// Shared types and constants for the SOCKS5 connect handshake parser.
// No dependencies; imported by every module of the block.
package s5c_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = 4;

  localparam logic [7:0] SocksVer    = 8'h05;
  localparam logic [7:0] CmdConnect  = 8'h01;
  localparam logic [7:0] AtypIpv4    = 8'h01;
  localparam logic [7:0] AtypDomain  = 8'h03;
  localparam logic [7:0] RepSuccess  = 8'h00;
  localparam logic [7:0] RepBadCmd   = 8'h07;
  localparam logic [7:0] RepBadAtyp  = 8'h08;
  localparam logic [7:0] MethNoAuth  = 8'h00;
  localparam logic [7:0] Ipv4Len     = 8'd4;

  localparam logic [1:0] KindTx     = 2'd0;
  localparam logic [1:0] KindHost   = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [2:0] StRunning  = 3'd0;
  localparam logic [2:0] StOk       = 3'd1;
  localparam logic [2:0] StBadVer   = 3'd2;
  localparam logic [2:0] StNoMeth   = 3'd3;
  localparam logic [2:0] StBadCmd   = 3'd4;
  localparam logic [2:0] StBadAtyp  = 3'd5;
  localparam logic [2:0] StEmptyDom = 3'd6;

  typedef enum logic [3:0] {
    PH_GVER, PH_NMETH, PH_METH, PH_RVER, PH_CMD, PH_RSV, PH_ATYP,
    PH_DLEN, PH_HOST, PH_PHI, PH_PLO, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    OP_STATUS, OP_HOST, OP_SELECT, OP_REPLY
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [15:0] port;
    logic       dom;
    logic [7:0] hlen;
    logic [2:0] status;
  } entry_t;

  function automatic logic [IdxW-1:0] op_last_idx(op_e op);
    case (op)
      OP_SELECT: op_last_idx = IdxW'(1);
      OP_REPLY:  op_last_idx = IdxW'(9);
      default:   op_last_idx = '0;
    endcase
  endfunction

  function automatic logic [7:0] reply_byte(logic [IdxW-1:0] idx, logic [7:0] code);
    case (idx)
      IdxW'(0): reply_byte = SocksVer;
      IdxW'(1): reply_byte = code;
      IdxW'(3): reply_byte = AtypIpv4;
      default:  reply_byte = 8'h00;
    endcase
  endfunction

endpackage

// ----- design/s5c_front.sv -----
// Front end: session parser, one client byte per cycle while accept_i is high; emits
// one command per byte that causes output. Depends on s5c_pkg.
module s5c_front import s5c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       session_start_i,
  output logic       push_o,
  output entry_t     entry_o
);

  phase_e     phase_q, phase_d, cur;
  logic [7:0] rem_q, rem_d, hcnt_q, hcnt_d, phi_q, phi_d;
  logic       dom_q, dom_d;
  logic [7:0] rem_dec;

  assign cur     = session_start_i ? PH_GVER : phase_q;
  assign rem_dec = rem_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GVER;
      rem_q   <= '0;
      hcnt_q  <= '0;
      phi_q   <= '0;
      dom_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      hcnt_q  <= hcnt_d;
      phi_q   <= phi_d;
      dom_q   <= dom_d;
    end
  end

  always_comb begin
    phase_d = cur;
    rem_d   = rem_q;
    hcnt_d  = hcnt_q;
    phi_d   = phi_q;
    dom_d   = dom_q;
    push_o  = 1'b0;
    entry_o = '{op: OP_STATUS, data: 8'h00, port: 16'h0000, dom: 1'b0,
                hlen: 8'h00, status: StRunning};
    case (cur)
      PH_GVER, PH_RVER: begin
        if (rx_byte_i != SocksVer) begin
          push_o         = accept_i;
          entry_o.status = StBadVer;
          phase_d        = PH_DONE;
        end else begin
          phase_d = (cur == PH_GVER) ? PH_NMETH : PH_CMD;
        end
      end
      PH_NMETH: begin
        if (rx_byte_i == 8'h00) begin
          push_o         = accept_i;
          entry_o.status = StNoMeth;
          phase_d        = PH_DONE;
        end else begin
          rem_d   = rx_byte_i;
          phase_d = PH_METH;
        end
      end
      PH_METH: begin
        rem_d = rem_dec;
        if (rem_dec == 8'h00) begin
          push_o     = accept_i;
          entry_o.op = OP_SELECT;
          phase_d    = PH_RVER;
        end
      end
      PH_CMD: begin
        if (rx_byte_i != CmdConnect) begin
          push_o         = accept_i;
          entry_o.op     = OP_REPLY;
          entry_o.data   = RepBadCmd;
          entry_o.status = StBadCmd;
          phase_d        = PH_DONE;
        end else begin
          phase_d = PH_RSV;
        end
      end
      PH_RSV: phase_d = PH_ATYP;
      PH_ATYP: begin
        if (rx_byte_i == AtypIpv4) begin
          dom_d   = 1'b0;
          hcnt_d  = Ipv4Len;
          rem_d   = Ipv4Len;
          phase_d = PH_HOST;
        end else if (rx_byte_i == AtypDomain) begin
          dom_d   = 1'b1;
          phase_d = PH_DLEN;
        end else begin
          push_o         = accept_i;
          entry_o.op     = OP_REPLY;
          entry_o.data   = RepBadAtyp;
          entry_o.status = StBadAtyp;
          phase_d        = PH_DONE;
        end
      end
      PH_DLEN: begin
        if (rx_byte_i == 8'h00) begin
          push_o         = accept_i;
          entry_o.status = StEmptyDom;
          phase_d        = PH_DONE;
        end else begin
          hcnt_d  = rx_byte_i;
          rem_d   = rx_byte_i;
          phase_d = PH_HOST;
        end
      end
      PH_HOST: begin
        push_o       = accept_i;
        entry_o.op   = OP_HOST;
        entry_o.data = rx_byte_i;
        entry_o.dom  = dom_q;
        entry_o.hlen = hcnt_q;
        rem_d        = rem_dec;
        if (rem_dec == 8'h00) phase_d = PH_PHI;
      end
      PH_PHI: begin
        phi_d   = rx_byte_i;
        phase_d = PH_PLO;
      end
      PH_PLO: begin
        push_o         = accept_i;
        entry_o.op     = OP_REPLY;
        entry_o.data   = RepSuccess;
        entry_o.port   = {phi_q, rx_byte_i};
        entry_o.dom    = dom_q;
        entry_o.hlen   = hcnt_q;
        entry_o.status = StOk;
        phase_d        = PH_DONE;
      end
      default: phase_d = PH_DONE;
    endcase
  end

endmodule

// ----- design/s5c_queue.sv -----
// Short command queue between parser and result sequencer.
// Depends on s5c_pkg.
module s5c_queue import s5c_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, rptr_q;
  logic [QCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QPtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/s5c_back.sv -----
// Back end: expands queued commands into result items into an output register.
// Depends on s5c_pkg.
module s5c_back import s5c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [IdxW-1:0] idx_q;
  logic            vld_q;
  logic [1:0]      kind_q, kind_d;
  logic [7:0]      data_q, data_d;
  entry_t          fld_q;
  logic            last_q, last_d;
  logic            load, take;

  assign load  = !vld_q || m_axis_tready;
  assign take  = load && !empty_i;
  assign last_d = (idx_q == op_last_idx(head_i.op));
  assign pop_o = take && last_d;

  always_comb begin
    case (head_i.op)
      OP_STATUS: begin kind_d = KindStatus; data_d = 8'h00; end
      OP_HOST:   begin kind_d = KindHost;   data_d = head_i.data; end
      OP_SELECT: begin kind_d = KindTx;     data_d = reply_byte(idx_q, MethNoAuth); end
      default:   begin kind_d = KindTx;     data_d = reply_byte(idx_q, head_i.data); end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) vld_q <= !empty_i;
      if (take) idx_q <= last_d ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      data_q <= data_d;
      fld_q  <= head_i;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {4'h0, fld_q.status, fld_q.hlen, fld_q.dom, fld_q.port, data_q};

endmodule

// ----- design/socks5_connect_handshake_parser.sv -----
// Top level of the SOCKS5 connect handshake parser (no authentication).
// Depends on s5c_pkg, s5c_front, s5c_queue, s5c_back.
//
//  channel | dir | tdata (low bit up)                               | tuser         | tlast
//  s_axis  | in  | rx_byte[7:0]                                     | session_start | -
//  m_axis  | out | data_byte, dest_port, addr_is_domain,            | item_kind     | last
//          |     | host_length, status, 4 zero bits                 |               |
//
// One client byte is taken per cycle while the 4-entry command queue has room.
// The output sequencer emits one result per cycle while m_axis_tready takes it; a reply
// burst is 10 results, the method selection 2, other results 1.
// Reset starts the parser at the greeting version with an empty queue.
// Output stalls back up through the queue to s_axis_tready only once it fills.
module socks5_connect_handshake_parser import s5c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // session_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_byte, dest_port, addr_is_domain,
                                      // host_length, status, pad
  output logic [1:0]  m_axis_tuser,   // item_kind
  output logic        m_axis_tlast
);

  logic   accept, push, pop, full, empty;
  entry_t entry, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  s5c_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .rx_byte_i       (s_axis_tdata),
    .session_start_i (s_axis_tuser),
    .push_o          (push),
    .entry_o         (entry)
  );

  s5c_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  s5c_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ----- dv/tb_socks5_connect_handshake_parser.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for socks5_connect_handshake_parser: drives client byte streams of
// SOCKS5 sessions and checks every output transfer against an in-bench session predictor.
// Depends on s5c_pkg and the design under dv test; needs no files or arguments.
module tb_socks5_connect_handshake_parser;
  import s5c_pkg::*;

  typedef struct packed {
    logic       start;
    logic [7:0] b;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] port;
    logic        dom;
    logic [7:0]  hlen;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef enum int {
    SK_IPV4, SK_DOMAIN, SK_BAD_GVER, SK_NO_METH, SK_BAD_RVER, SK_BAD_CMD,
    SK_BAD_ATYP, SK_EMPTY_DOM, SK_TRUNC, SK_NOISE
  } sess_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rx_item_t  rx_pending[$];
  out_item_t expected_out[$];
  bit        rx_taken = 1'b0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        stim_items = 0;
  int        out_cnt = 0;
  int        mismatch_cnt = 0;

  // predictor state
  phase_e     sess_phase;
  logic [7:0] bytes_left;
  logic [7:0] host_cnt;
  logic [7:0] port_hi;
  logic       dom_mode;

  socks5_connect_handshake_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %h want %h", out_cnt, name, got, want));
    end
  endtask

  task automatic reset_parser();
    sess_phase = PH_GVER;
    bytes_left = 8'h00;
    host_cnt   = 8'h00;
    port_hi    = 8'h00;
    dom_mode   = 1'b0;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic [15:0] port, input logic dom, input logic [7:0] hlen,
                             input logic [2:0] st, input logic last);
    out_item_t item;
    item.kind   = kind;
    item.data   = data;
    item.port   = port;
    item.dom    = dom;
    item.hlen   = hlen;
    item.status = st;
    item.last   = last;
    expected_out.push_back(item);
  endtask

  task automatic push_reply(input logic [7:0] code, input logic [15:0] port, input logic dom,
                            input logic [7:0] hlen, input logic [2:0] st);
    logic [7:0] v;
    for (int i = 0; i < 10; i++) begin
      case (i)
        0:       v = SocksVer;
        1:       v = code;
        3:       v = AtypIpv4;
        default: v = 8'h00;
      endcase
      push_result(KindTx, v, port, dom, hlen, st, i == 9);
    end
  endtask

  task automatic predict_socks(input logic [7:0] b, input logic start);
    if (start) reset_parser();
    case (sess_phase)
      PH_GVER: begin
        if (b != SocksVer) begin
          push_result(KindStatus, 8'h00, 16'h0, 1'b0, 8'h00, StBadVer, 1'b1);
          sess_phase = PH_DONE;
        end else begin
          sess_phase = PH_NMETH;
        end
      end
      PH_NMETH: begin
        if (b == 8'h00) begin
          push_result(KindStatus, 8'h00, 16'h0, 1'b0, 8'h00, StNoMeth, 1'b1);
          sess_phase = PH_DONE;
        end else begin
          bytes_left = b;
          sess_phase = PH_METH;
        end
      end
      PH_METH: begin
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) begin
          push_result(KindTx, SocksVer, 16'h0, 1'b0, 8'h00, StRunning, 1'b0);
          push_result(KindTx, MethNoAuth, 16'h0, 1'b0, 8'h00, StRunning, 1'b1);
          sess_phase = PH_RVER;
        end
      end
      PH_RVER: begin
        if (b != SocksVer) begin
          push_result(KindStatus, 8'h00, 16'h0, 1'b0, 8'h00, StBadVer, 1'b1);
          sess_phase = PH_DONE;
        end else begin
          sess_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        if (b != CmdConnect) begin
          push_reply(RepBadCmd, 16'h0, 1'b0, 8'h00, StBadCmd);
          sess_phase = PH_DONE;
        end else begin
          sess_phase = PH_RSV;
        end
      end
      PH_RSV: sess_phase = PH_ATYP;
      PH_ATYP: begin
        if (b == AtypIpv4) begin
          dom_mode   = 1'b0;
          host_cnt   = Ipv4Len;
          bytes_left = Ipv4Len;
          sess_phase = PH_HOST;
        end else if (b == AtypDomain) begin
          dom_mode   = 1'b1;
          sess_phase = PH_DLEN;
        end else begin
          push_reply(RepBadAtyp, 16'h0, 1'b0, 8'h00, StBadAtyp);
          sess_phase = PH_DONE;
        end
      end
      PH_DLEN: begin
        if (b == 8'h00) begin
          push_result(KindStatus, 8'h00, 16'h0, 1'b0, 8'h00, StEmptyDom, 1'b1);
          sess_phase = PH_DONE;
        end else begin
          host_cnt   = b;
          bytes_left = b;
          sess_phase = PH_HOST;
        end
      end
      PH_HOST: begin
        push_result(KindHost, b, 16'h0, dom_mode, host_cnt, StRunning, 1'b1);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) sess_phase = PH_PHI;
      end
      PH_PHI: begin
        port_hi    = b;
        sess_phase = PH_PLO;
      end
      PH_PLO: begin
        push_reply(RepSuccess, {port_hi, b}, dom_mode, host_cnt, StOk);
        sess_phase = PH_DONE;
      end
      default: sess_phase = PH_DONE;
    endcase
  endtask

  function automatic logic [7:0] pick_other(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == a || v == c) v = 8'($urandom_range(255));
    return v;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_item_t item;
    item.start = start;
    item.b     = b;
    rx_pending.push_back(item);
    stim_items++;
  endtask

  task automatic build_session(input sess_kind_e kind, input bit big);
    logic [7:0] seq[$];
    int         nmeth;
    int         hlen;
    int         r;
    int         cut;
    bit         dom;
    if (kind == SK_NOISE) begin
      cut = $urandom_range(8, 1);
      repeat (cut) queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      return;
    end
    dom = (kind == SK_DOMAIN || kind == SK_EMPTY_DOM) ||
          (kind != SK_IPV4 && $urandom_range(1) == 1);
    nmeth = (big && !dom) ? 255 : $urandom_range(4, 1);
    hlen  = (big && dom) ? 255 : $urandom_range(12, 1);
    seq.push_back(SocksVer);
    seq.push_back(8'(nmeth));
    repeat (nmeth) seq.push_back(8'($urandom_range(255)));
    r = seq.size();
    seq.push_back(SocksVer);
    seq.push_back(CmdConnect);
    seq.push_back(8'($urandom_range(255)));
    if (dom) begin
      seq.push_back(AtypDomain);
      seq.push_back(8'(hlen));
      repeat (hlen) seq.push_back(8'($urandom_range(255)));
    end else begin
      seq.push_back(AtypIpv4);
      repeat (4) seq.push_back(8'($urandom_range(255)));
    end
    seq.push_back(8'($urandom_range(255)));
    seq.push_back(8'($urandom_range(255)));
    cut = seq.size();
    case (kind)
      SK_BAD_GVER: begin
        seq[0] = pick_other(SocksVer, SocksVer);
        cut = 1;
      end
      SK_NO_METH: begin
        seq[1] = 8'h00;
        cut = 2;
      end
      SK_BAD_RVER: begin
        seq[r] = pick_other(SocksVer, SocksVer);
        cut = r + 1;
      end
      SK_BAD_CMD: begin
        seq[r+1] = pick_other(CmdConnect, CmdConnect);
        cut = r + 2;
      end
      SK_BAD_ATYP: begin
        seq[r+3] = pick_other(AtypIpv4, AtypDomain);
        cut = r + 4;
      end
      SK_EMPTY_DOM: begin
        seq[r+4] = 8'h00;
        cut = r + 5;
      end
      SK_TRUNC: cut = $urandom_range(seq.size() - 1, 1);
      default: ;
    endcase
    for (int i = 0; i < cut; i++) queue_byte(seq[i], i == 0);
    // trailing bytes after the session has ended are dropped by the block
    if (kind != SK_TRUNC) begin
      repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic wait_drain();
    while (rx_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_out.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : rx_drive
    rx_item_t cur;
    if (rst_ni && (!s_axis_tvalid || rx_taken)) begin
      rx_taken = 1'b0;
      if (rx_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur = rx_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cur.b;
        s_axis_tuser  <= cur.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : mon
    out_item_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_socks(s_axis_tdata, s_axis_tuser);
        rx_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("result %0d unexpected: tdata %h tuser %h tlast %b",
                                    out_cnt, m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = expected_out.pop_front();
          check_field("item_kind", 16'(m_axis_tuser), 16'(want.kind));
          check_field("data_byte", 16'(m_axis_tdata[7:0]), 16'(want.data));
          check_field("dest_port", m_axis_tdata[23:8], want.port);
          check_field("addr_is_domain", 16'(m_axis_tdata[24]), 16'(want.dom));
          check_field("host_length", 16'(m_axis_tdata[32:25]), 16'(want.hlen));
          check_field("status", 16'(m_axis_tdata[35:33]), 16'(want.status));
          check_field("pad", 16'(m_axis_tdata[39:36]), 16'h0);
          check_field("last", 16'(m_axis_tlast), 16'(want.last));
        end
        out_cnt++;
      end
    end
  end

  initial begin : stim
    int         sess_no;
    int         roll;
    int         stim_goal;
    bit         big;
    sess_kind_e kind;
    sess_no = 0;
    reset_parser();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no start flag: IPv4 connect with all-ones method, reserved, host and port
    queue_byte(8'h05, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'h05, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    repeat (6) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    // bad greeting version, no methods, bad request version, bad command
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h05, 1'b1); queue_byte(8'h00, 1'b0);
    queue_byte(8'h05, 1'b1); queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h05, 1'b1); queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h05, 1'b0); queue_byte(8'h00, 1'b0);
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 49; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      // one long domain name
      if (ph == 2) build_session(SK_DOMAIN, 1'b1);
      stim_goal = stim_items + 40;
      while (stim_items < stim_goal) begin
        if (sess_no < 10) begin
          kind = sess_kind_e'(sess_no);
        end else begin
          roll = $urandom_range(99);
          if (roll < 30)      kind = SK_IPV4;
          else if (roll < 55) kind = SK_DOMAIN;
          else if (roll < 75) kind = sess_kind_e'($urandom_range(SK_EMPTY_DOM, SK_BAD_GVER));
          else if (roll < 90) kind = SK_TRUNC;
          else                kind = SK_NOISE;
        end
        big = 1'b0;
        build_session(kind, big);
        sess_no++;
      end
      wait_drain();
    end

    repeat (40) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_out.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("[socks5_connect_handshake_parser] OK");
    end else begin
      $display("[socks5_connect_handshake_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[socks5_connect_handshake_parser] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/s5c_pkg.sv
design/s5c_front.sv
design/s5c_queue.sv
design/s5c_back.sv
design/socks5_connect_handshake_parser.sv
dv/tb_socks5_connect_handshake_parser.sv
